/* sv/fixed_video_timing_matcher_assert.svh */
// Assertion macros for the fixed video timing matcher.
`ifndef FIXED_VIDEO_TIMING_MATCHER_ASSERT_SVH
`define FIXED_VIDEO_TIMING_MATCHER_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define FVTM_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define FVTM_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

/* sv/fvtm_pkg.sv */
// Shared types and constants for the fixed video timing matcher.
package fvtm_pkg;

    localparam logic [2:0] OP_LOAD_H  = 3'd0;
    localparam logic [2:0] OP_LOAD_V  = 3'd1;
    localparam logic [2:0] OP_PROPOSE = 3'd2;
    localparam logic [2:0] OP_ADJUST  = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_MATCH = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_ZERO     = 2'd3;

    localparam int FW = 13;

    typedef struct packed {
        logic        pol;
        logic [12:0] total;
        logic [12:0] blank_end;
        logic [12:0] sync_end;
        logic [12:0] sync_start;
        logic [12:0] blank_start;
        logic [12:0] width;
    } timing_t;

endpackage

/* sv/fixed_video_timing_matcher.sv */
// Top level of the fixed video timing matcher: timing table, search and scaling.
//
// Usage:
//   Input beats arrive on s_axis (tvalid/tready/tdata); each operation yields
//   zero, one or two result beats on m_axis, the final one flagged by tlast.
//   Load horizontal stages a timing; load vertical appends the staged
//   horizontal timing and the new vertical timing as one table entry; clear
//   empties the table. Propose and adjust search from the newest entry down.
//   Entries live in one synchronous memory (one read port, registered read data).
// Sequence:
//   Loads and clear pass through the status state, which places their status
//   beat in the output register. A search reads, then checks, one entry at a
//   time (states read, check) and moves on while the line count differs. A
//   line-count match adds a 37-step restoring division for the pixel clock;
//   a hit adds six more 37-step divisions for the scaled positions, then the
//   two result beats.
//   One item is in work at a time; s_tready is high only in the idle state.
// Reset:
//   aresetn (synchronous, low) empties the table and the staged timing.
//   Memory contents stay undefined; only entries below the count are read.
// Stalls:
//   A result is held in the output register until m_axis_tready takes it;
//   the search does not advance while a result waits.
module fixed_video_timing_matcher
    import fvtm_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata from bit 0: operation(3) dots_x(12) dots_y(12) requested_dclk(30)
    // width blank_start sync_start sync_end blank_end total (13 each) polarity(1)
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata from bit 0: status(2) pixel_clock(32) out_width out_blank_start
    // out_sync_start out_sync_end out_blank_end out_total (13 each) out_polarity(1)
    output logic [119:0] m_axis_tdata,
    // tuser: axis(1)
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int QW = 37;   // quotient width for dx*100000
    localparam int NW = 37;   // numerator width

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_CLK   = 4'd4;
    localparam logic [3:0] S_SCL   = 4'd5;
    localparam logic [3:0] S_OUT0  = 4'd6;
    localparam logic [3:0] S_OUT1  = 4'd7;
    localparam logic [3:0] S_NOM   = 4'd8;
    localparam logic [3:0] S_STAT  = 4'd9;

    // input unpack
    logic [2:0]  in_op;
    logic [11:0] in_dx, in_dy;
    logic [29:0] in_req;
    timing_t     in_t;
    assign in_op  = s_axis_tdata[2:0];
    assign in_dx  = s_axis_tdata[14:3];
    assign in_dy  = s_axis_tdata[26:15];
    assign in_req = s_axis_tdata[56:27];
    assign in_t   = s_axis_tdata[135:57];

    // table memory: horizontal and vertical timing per entry
    logic [157:0] mem [TABLE_DEPTH];
    logic [157:0] rd_data_reg;
    logic         wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [157:0] wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;     // entries left to search
    timing_t       staged_reg, staged_next;
    logic          adj_reg, adj_next;
    logic [11:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic [29:0]   req_reg, req_next;
    timing_t       h_reg, h_next, v_reg, v_next;
    logic [1:0]    stat_reg, stat_next;

    // shared serial divider: num / den, one quotient bit a cycle
    logic [NW-1:0] num_reg, num_next;
    logic [12:0]   den_reg, den_next;
    logic [13:0]   rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [5:0]    step_reg, step_next;
    logic [2:0]    fld_reg, fld_next;   // 0 = clock, 1..6 = scaled fields
    logic [50:0]   pclk_reg, pclk_next; // full-width (unsaturated) pixel clock
    timing_t       xs_reg, xs_next;

    // output register
    logic         ov_reg, ov_next;
    logic [119:0] od_reg, od_next;
    logic         ou_reg, ou_next, ol_reg, ol_next;

    logic [13:0] rem_sh;
    logic [55:0] diff_abs;
    logic        in_window;
    logic [12:0] sat13;

    assign s_axis_tready = (state_reg == S_IDLE) && !ov_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ou_reg;
    assign m_axis_tlast  = ol_reg;

    assign rem_sh   = {rem_reg[12:0], num_reg[NW-1]};
    assign diff_abs = ({26'd0, req_reg} > {5'd0, pclk_reg}) ?
                      ({26'd0, req_reg} - {5'd0, pclk_reg}) :
                      ({5'd0, pclk_reg} - {26'd0, req_reg});
    // 100 * diff < 2 * clock, with 100 * diff built from shifts
    assign in_window = ((({7'd0, diff_abs} << 6) + ({7'd0, diff_abs} << 5)
                         + ({7'd0, diff_abs} << 2)) < {11'd0, pclk_reg, 1'b0});
    assign sat13 = (quo_reg > QW'(8191)) ? 13'h1FFF : quo_reg[12:0];

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        staged_next = staged_reg;
        adj_next    = adj_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        req_next    = req_reg;
        h_next      = h_reg;
        v_next      = v_reg;
        stat_next   = stat_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        step_next   = step_reg;
        fld_next    = fld_reg;
        pclk_next   = pclk_reg;
        xs_next     = xs_reg;
        ov_next     = ov_reg;
        od_next     = od_reg;
        ou_next     = ou_reg;
        ol_next     = ol_reg;
        wr_en       = 1'b0;
        wr_addr     = count_reg[AW-1:0];
        wr_data     = {in_t, staged_reg};
        rd_addr     = AW'(idx_reg - CW'(1));

        if (ov_reg && m_axis_tready) begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    dx_next  = in_dx;
                    dy_next  = in_dy;
                    req_next = in_req;
                    adj_next = (in_op == OP_ADJUST);
                    idx_next = count_reg;
                    case (in_op)
                        OP_LOAD_H: begin
                            if (in_t.width == 13'd0) begin
                                stat_next = ST_ZERO;
                            end else begin
                                staged_next = in_t;
                                stat_next   = ST_OK;
                            end
                            state_next = S_STAT;
                        end
                        OP_LOAD_V: begin
                            if (staged_reg.width == 13'd0 || in_t.width == 13'd0) begin
                                stat_next = ST_ZERO;
                            end else if (count_reg >= CW'(TABLE_DEPTH)) begin
                                stat_next = ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                                stat_next  = ST_OK;
                            end
                            state_next = S_STAT;
                        end
                        OP_CLEAR: begin
                            count_next  = '0;
                            staged_next = '0;
                            stat_next   = ST_OK;
                            state_next  = S_STAT;
                        end
                        OP_PROPOSE, OP_ADJUST: begin
                            state_next = (count_reg == '0) ? S_NOM : S_RD;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_RD: begin
                // memory read issued on rd_addr; data valid next cycle
                state_next = S_CHK;
            end
            S_CHK: begin
                h_next = rd_data_reg[78:0];
                v_next = rd_data_reg[157:79];
                idx_next = idx_reg - CW'(1);
                if (rd_data_reg[91:79] == {1'b0, dy_reg} && rd_data_reg[12:0] != 13'd0) begin
                    num_next   = NW'({25'd0, dx_reg} * 37'd100000);
                    den_next   = rd_data_reg[12:0];
                    rem_next   = '0;
                    quo_next   = '0;
                    step_next  = 6'(NW);
                    fld_next   = 3'd0;
                    state_next = S_DIV;
                end else if (idx_reg == CW'(1)) begin
                    state_next = S_NOM;
                end else begin
                    state_next = S_RD;
                end
            end
            S_DIV: begin
                num_next  = {num_reg[NW-2:0], 1'b0};
                if (rem_sh >= {1'b0, den_reg}) begin
                    rem_next = rem_sh - {1'b0, den_reg};
                    quo_next = {quo_reg[QW-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[QW-2:0], 1'b0};
                end
                step_next = step_reg - 6'd1;
                if (step_reg == 6'd1) begin
                    state_next = (fld_reg == 3'd0) ? S_CLK : S_SCL;
                end
            end
            S_CLK: begin
                // quotient times 10000; the quotient never exceeds 29 bits
                pclk_next  = {22'd0, quo_reg[28:0]} * 51'd10000;
                state_next = S_SCL;
                fld_next   = 3'd0;
            end
            S_SCL: begin
                if (fld_reg == 3'd0) begin
                    if (adj_reg && !in_window) begin
                        state_next = (idx_reg == '0) ? S_NOM : S_RD;
                    end else begin
                        fld_next = 3'd1;
                        num_next = NW'(h_reg.width) * NW'(dx_reg);
                        rem_next = '0;
                        quo_next = '0;
                        step_next = 6'(NW);
                        state_next = S_DIV;
                    end
                end else begin
                    case (fld_reg)
                        3'd1: xs_next.width       = sat13;
                        3'd2: xs_next.blank_start = sat13;
                        3'd3: xs_next.sync_start  = sat13;
                        3'd4: xs_next.sync_end    = sat13;
                        3'd5: xs_next.blank_end   = sat13;
                        default: xs_next.total    = sat13;
                    endcase
                    if (fld_reg == 3'd6) begin
                        xs_next.pol = h_reg.pol;
                        state_next  = S_OUT0;
                    end else begin
                        fld_next  = fld_reg + 3'd1;
                        rem_next  = '0;
                        quo_next  = '0;
                        step_next = 6'(NW);
                        state_next = S_DIV;
                        case (fld_reg)
                            3'd1: num_next = NW'(h_reg.blank_start) * NW'(dx_reg);
                            3'd2: num_next = NW'(h_reg.sync_start) * NW'(dx_reg);
                            3'd3: num_next = NW'(h_reg.sync_end) * NW'(dx_reg);
                            3'd4: num_next = NW'(h_reg.blank_end) * NW'(dx_reg);
                            default: num_next = NW'(h_reg.total) * NW'(dx_reg);
                        endcase
                    end
                end
            end
            S_OUT0: begin
                if (!ov_reg) begin
                    ov_next = 1'b1;
                    od_next = {7'd0, xs_reg, (pclk_reg > 51'hFFFFFFFF) ? 32'hFFFFFFFF :
                               pclk_reg[31:0], ST_OK};
                    ou_next = 1'b0;
                    ol_next = 1'b0;
                    state_next = S_OUT1;
                end
            end
            S_OUT1: begin
                if (!ov_reg) begin
                    ov_next = 1'b1;
                    od_next = {7'd0, v_reg, od_reg[33:2], ST_OK};
                    ou_next = 1'b1;
                    ol_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_NOM: begin
                if (!ov_reg) begin
                    ov_next = 1'b1;
                    od_next = {118'd0, ST_NO_MATCH};
                    ou_next = 1'b0;
                    ol_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_STAT: begin
                if (!ov_reg) begin
                    ov_next = 1'b1;
                    od_next = {118'd0, stat_reg};
                    ou_next = 1'b0;
                    ol_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            staged_reg <= '0;
            ov_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            staged_reg <= staged_next;
            ov_reg     <= ov_next;
        end
        idx_reg  <= idx_next;
        adj_reg  <= adj_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        req_reg  <= req_next;
        h_reg    <= h_next;
        v_reg    <= v_next;
        stat_reg <= stat_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        fld_reg  <= fld_next;
        pclk_reg <= pclk_next;
        xs_reg   <= xs_next;
        od_reg   <= od_next;
        ou_reg   <= ou_next;
        ol_reg   <= ol_next;
    end

`include "fixed_video_timing_matcher_assert.svh"

    `FVTM_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(TABLE_DEPTH), "entry count exceeds depth")
    `FVTM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `FVTM_ASSERT_IMPL(a_busy_no_accept, aclk, aresetn, state_reg != S_IDLE, !s_axis_tready, "input accepted while busy")

endmodule

/* test/fixed_video_timing_matcher_test.sv */
// Testbench for the fixed video timing matcher: predicts every result beat and checks it.
`timescale 1ns / 1ps

// Holds a copy of the timing table and the queue of result beats still to come.
class timing_scoreboard;
    typedef struct packed {
        logic [1:0]   status;
        logic         axis;
        logic [31:0]  pixel_clock;
        fvtm_pkg::timing_t tm;
        logic         last;
    } result_t;

    fvtm_pkg::timing_t horiz_table[32];
    fvtm_pkg::timing_t vert_table[32];
    fvtm_pkg::timing_t staged;
    int               count;
    result_t          pending[$];
    int               errors;

    function void clear_all();
        staged = '0;
        count = 0;
        pending.delete();
        errors = 0;
    endfunction

    function void push_status(logic [1:0] st);
        result_t r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        pending.push_back(r);
    endfunction

    // Search newest entry first; scale the horizontal timing on a hit.
    function void search(logic [2:0] op, logic [11:0] dx, logic [11:0] dy, logic [29:0] req);
        longint unsigned hw, clk, diff, p;
        logic [12:0] hf[6];
        logic [12:0] sf[6];
        result_t r;
        for (int e = count - 1; e >= 0; e--) begin
            hw = horiz_table[e].width;
            if (vert_table[e].width != dy || hw == 0) continue;
            clk = ((longint'(dx) * 100000) / hw) * 10000;
            if (op == fvtm_pkg::OP_ADJUST) begin
                diff = (req > clk) ? req - clk : clk - req;
                if (!(100 * diff < 2 * clk)) continue;
            end
            hf = '{horiz_table[e].width, horiz_table[e].blank_start,
                   horiz_table[e].sync_start, horiz_table[e].sync_end,
                   horiz_table[e].blank_end, horiz_table[e].total};
            for (int i = 0; i < 6; i++) begin
                p = (longint'(dx) * hf[i]) / hw;
                sf[i] = (p > 8191) ? 13'd8191 : p[12:0];
            end
            if (clk > 64'hFFFF_FFFF) clk = 64'hFFFF_FFFF;
            r = '0;
            r.pixel_clock = clk[31:0];
            r.tm = '{pol: horiz_table[e].pol, total: sf[5], blank_end: sf[4],
                     sync_end: sf[3], sync_start: sf[2], blank_start: sf[1],
                     width: sf[0]};
            pending.push_back(r);
            r.axis = 1'b1;
            r.tm = vert_table[e];
            r.last = 1'b1;
            pending.push_back(r);
            return;
        end
        push_status(fvtm_pkg::ST_NO_MATCH);
    endfunction

    // Note one accepted input beat.
    function void note_request(logic [135:0] d);
        logic [2:0] op;
        fvtm_pkg::timing_t ld;
        op = d[2:0];
        ld = d[135:57];
        case (op)
            fvtm_pkg::OP_LOAD_H: begin
                if (ld.width == 0) push_status(fvtm_pkg::ST_ZERO);
                else begin
                    staged = ld;
                    push_status(fvtm_pkg::ST_OK);
                end
            end
            fvtm_pkg::OP_LOAD_V: begin
                if (staged.width == 0 || ld.width == 0) push_status(fvtm_pkg::ST_ZERO);
                else if (count >= 32) push_status(fvtm_pkg::ST_FULL);
                else begin
                    horiz_table[count] = staged;
                    vert_table[count] = ld;
                    count++;
                    push_status(fvtm_pkg::ST_OK);
                end
            end
            fvtm_pkg::OP_CLEAR: begin
                count = 0;
                staged = '0;
                push_status(fvtm_pkg::ST_OK);
            end
            fvtm_pkg::OP_PROPOSE, fvtm_pkg::OP_ADJUST: search(op, d[14:3], d[26:15], d[56:27]);
            default: ;
        endcase
    endfunction

    // Check one result beat against the oldest expectation.
    function void check_result(logic [119:0] d, logic user, logic last);
        result_t got, want;
        got.status = d[1:0];
        got.pixel_clock = d[33:2];
        got.tm = d[112:34];
        got.axis = user;
        got.last = last;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.status !== want.status)
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
        if (got.axis !== want.axis)
            $display("%0t: axis exp %0d got %0d", $time, want.axis, got.axis);
        if (got.pixel_clock !== want.pixel_clock)
            $display("%0t: pixel_clock exp %0d got %0d", $time, want.pixel_clock,
                     got.pixel_clock);
        if (got.tm !== want.tm)
            $display("%0t: timing exp %h got %h", $time, want.tm, got.tm);
        if (got.last !== want.last)
            $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
        if (got !== want) errors++;
    endfunction
endclass

module fixed_video_timing_matcher_test;
    import fvtm_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [119:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    timing_scoreboard mode_table = new();

    // Idle control: randomness toggled off during the quiet stretch.
    bit  idle_on = 1'b1;
    bit  sink_hold = 1'b0;
    int  cycle_count = 0;

    // Dimensions reused so searches actually hit entries.
    logic [11:0] used_lines[$];

    fixed_video_timing_matcher #(.TABLE_DEPTH(32)) u_dut (
        .aclk, .aresetn, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Timeout: a run that does not finish is reported as failed.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 4000000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Sample result beats at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            mode_table.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // Drive the result ready at the falling edge; hold it low on request.
    always @(negedge aclk) begin
        if (sink_hold) m_axis_tready <= 1'b0;
        else m_axis_tready <= !(idle_on && $urandom_range(99) < 19);
    end

    // Offer one beat, with random gaps, and advance once it is taken.
    task automatic send_beat(logic [135:0] d);
        while (idle_on && $urandom_range(99) < 19) @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        do @(posedge aclk); while (!s_axis_tready);
        mode_table.note_request(d);
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [135:0] pack_beat(logic [2:0] op, logic [11:0] dx,
                                               logic [11:0] dy, logic [29:0] req,
                                               timing_t tm);
        return {tm, req, dy, dx, op};
    endfunction

    function automatic timing_t rand_timing(logic [12:0] w);
        timing_t t;
        t.width = w;
        t.blank_start = $urandom_range(8191);
        t.sync_start = $urandom_range(8191);
        t.sync_end = $urandom_range(8191);
        t.blank_end = $urandom_range(8191);
        t.total = $urandom_range(8191);
        t.pol = $urandom_range(1);
        return t;
    endfunction

    // Requested clock close to that of a random stored entry, or random.
    function automatic logic [29:0] pick_clock(logic [11:0] dx);
        longint unsigned clk;
        int e;
        if (mode_table.count == 0 || $urandom_range(3) == 0) return $urandom_range(1000000000);
        e = $urandom_range(mode_table.count - 1);
        clk = ((longint'(dx) * 100000) / mode_table.horiz_table[e].width) * 10000;
        clk = clk + (clk / 1000) * $urandom_range(40) - (clk / 1000) * 20;
        return (clk > 1000000000) ? 30'd1000000000 : clk[29:0];
    endfunction

    task automatic load_entry(logic [12:0] hw, logic [12:0] vw);
        send_beat(pack_beat(OP_LOAD_H, $urandom, $urandom, $urandom, rand_timing(hw)));
        send_beat(pack_beat(OP_LOAD_V, $urandom, $urandom, $urandom, rand_timing(vw)));
        used_lines.push_back(vw[11:0]);
    endtask

    task automatic random_beat();
        int k;
        logic [11:0] dx, dy;
        logic [12:0] w;
        k = $urandom_range(99);
        dx = ($urandom_range(9) == 0) ? 12'hFFF : $urandom_range(4095);
        dy = (used_lines.size() > 0 && $urandom_range(3) != 0) ?
             used_lines[$urandom_range(used_lines.size() - 1)] : $urandom_range(4095);
        w = ($urandom_range(4) == 0) ? $urandom_range(8191) : $urandom_range(1, 64);
        if (k < 35) load_entry(w, (used_lines.size() > 0 && $urandom_range(1)) ?
                               {1'b0, dy} : $urandom_range(8191));
        else if (k < 60) send_beat(pack_beat(OP_PROPOSE, dx, dy, $urandom, rand_timing(w)));
        else if (k < 85) send_beat(pack_beat(OP_ADJUST, dx, dy, pick_clock(dx),
                                             rand_timing(w)));
        else if (k < 88) begin
            send_beat(pack_beat(OP_CLEAR, $urandom, $urandom, $urandom, rand_timing(w)));
            used_lines.delete();
        end else if (k < 93) send_beat(pack_beat(OP_LOAD_H, dx, dy, $urandom,
                                                 rand_timing($urandom_range(1) ? 13'd0 : w)));
        else if (k < 97) send_beat(pack_beat(OP_LOAD_V, dx, dy, $urandom,
                                             rand_timing($urandom_range(1) ? 13'd0 : w)));
        else send_beat(pack_beat($urandom_range(5, 7), dx, dy, $urandom, rand_timing(w)));
    endtask

    task automatic wait_drained();
        while (mode_table.pending.size() != 0) @(negedge aclk);
    endtask

    timing_t ones;

    initial begin
        mode_table.clear_all();
        ones = '1;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty searches, rejected loads, extremes, unused codes.
        send_beat(pack_beat(OP_PROPOSE, 12'd640, 12'd480, '0, '0));
        send_beat(pack_beat(OP_ADJUST, 12'd640, 12'd480, 30'd25000000, '0));
        send_beat(pack_beat(OP_LOAD_V, '0, '0, '0, ones));      // nothing staged
        send_beat(pack_beat(OP_LOAD_H, '1, '1, '1, '0));        // zero width
        send_beat(pack_beat(OP_LOAD_H, '0, '0, '0, ones));
        send_beat(pack_beat(OP_LOAD_V, '0, '0, '0, '0));        // zero vertical width
        send_beat(pack_beat(OP_LOAD_V, '0, '0, '0, rand_timing(13'd4095)));
        used_lines.push_back(12'd4095);
        load_entry(13'd1, 13'd480);                             // saturating scale
        send_beat(pack_beat(OP_PROPOSE, 12'hFFF, 12'd480, '1, '0));
        send_beat(pack_beat(OP_PROPOSE, 12'hFFF, 12'd4095, '0, '0));
        send_beat(pack_beat(OP_ADJUST, 12'd640, 12'd480, 30'd1000000000, ones));
        send_beat(pack_beat(OP_PROPOSE, 12'd0, 12'd480, '0, '0));
        send_beat(pack_beat(3'd7, '1, '1, '1, ones));
        send_beat(pack_beat(3'd5, '0, '0, '0, '0));
        send_beat(pack_beat(OP_CLEAR, '1, '1, '1, ones));
        used_lines.delete();
        send_beat(pack_beat(OP_PROPOSE, 12'd640, 12'd4095, '0, '0));
        // Fill the table past its depth.
        for (int i = 0; i < 33; i++) load_entry($urandom_range(1, 8191), 13'd600 + i);
        send_beat(pack_beat(OP_PROPOSE, 12'd800, 12'd600, '0, '0));   // oldest entry
        wait_drained();

        // Receiver holds off a long stretch while the sender keeps offering.
        fork
            begin
                sink_hold = 1'b1;
                repeat (3000) @(negedge aclk);
                sink_hold = 1'b0;
            end
            for (int i = 0; i < 12; i++) random_beat();
        join

        // Random traffic, with a quiet stretch free of gaps in the middle.
        for (int i = 0; i < 320; i++) begin
            if (i == 100) idle_on = 1'b0;
            if (i == 160) idle_on = 1'b1;
            if (i == 220) wait_drained();   // sender pause until all results are back
            random_beat();
        end

        wait_drained();
        repeat (2000) @(negedge aclk);
        if (mode_table.errors == 0 && mode_table.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

/* fixed_video_timing_matcher.f */
+incdir+sv
sv/fvtm_pkg.sv
sv/fixed_video_timing_matcher.sv
test/fixed_video_timing_matcher_test.sv
